// ===== rtl/bbma_pkg.sv =====
`default_nettype none

package bbma_pkg;

    // Map geometry
    localparam int MAX_BLOCKS  = 4096;
    localparam int INDEX_RANGE = 4096;
    localparam int LIMIT_CAP   = (MAX_BLOCKS < INDEX_RANGE) ? MAX_BLOCKS : INDEX_RANGE;
    localparam int IDX_W       = 12;
    localparam int LIM_W       = 13;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int NUM_WORDS   = MAX_BLOCKS / WORD_W;
    localparam int ADDR_W      = $clog2(NUM_WORDS);

    // Stream payload layout
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_VAL_BIT  = IDX_W;
    localparam int OUT_OCC_BIT = IDX_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT      = 2'd1;
    localparam logic [LIM_W-1:0]     RST_BLOCK_COUNT      = 13'd4096;

    // Request codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RSVD  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;     // capture request
        logic rd_en;    // read map word
        logic rd_next;  // read the following word, advance word pointer
        logic wr_en;    // write back modified word
        logic res_ld;   // capture result
        logic out_ld;   // move result to output register
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_oor;
        logic            start_oor;
        logic            hit;
        logic            last_word;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/block_bitmap_allocator_unit.sv =====
`default_nettype none

// Block occupancy bitmap with first-fit allocation. One bit per block (1 used,
// 0 free) for up to 4096 blocks, held as 128 words of 32 bits; every block is
// free after reset (each word has a valid flag cleared by reset, so there is
// no clearing pass and the unit takes requests straight away). A request
// (tuser opcode) reads a bit, writes a bit, or allocates: allocate scans up
// from first_data_block to the block limit, marks the first free block used
// and returns it, or reports no free block. Indices at or above the limit
// give status "out of range" and leave the map alone. Opcode three is a
// no-op returning ok. One request is in flight at a time. Read and write
// requests go from dispatch through one map word read to result load;
// out-of-range requests, opcode three and an allocate whose scan start lies
// at or beyond the limit load their result in dispatch with no map read, and
// allocate scans map words (one 32-bit word per cycle through the single map
// read port, up to 128) until a free block or the limit. The input is ready
// again once the result has moved to the output register; a result waiting
// there holds the next one back until the receiver takes it. A finished
// result sits in the output register while the next request is accepted.
// Configuration (index 0 first_data_block, 1 block_count) is for the user to
// write only while no request is outstanding; the unit does not enforce it.

module block_bitmap_allocator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [bbma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // block_index[11:0], bit_value[12]
    input  wire logic [bbma_pkg::OP_W-1:0]           s_axis_tuser,  // opcode[1:0]
    // result
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [bbma_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // result_block[11:0], occupied[12]
    output logic [bbma_pkg::STATUS_W-1:0]            m_axis_tuser,  // status[1:0]
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bbma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bbma_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bbma_pkg::t_cmd w_cmd;
    bbma_pkg::t_sts w_sts;

    // registers always accept; the user must write only while idle, the unit does not enforce it
    assign o_cfg_ready = 1'b1;

    bbma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bbma_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_data   (s_axis_tdata),
        .i_req_op     (s_axis_tuser),
        .i_cfg_wr     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_data   (m_axis_tdata),
        .o_res_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/bbma_ctrl.sv =====
`default_nettype none

module bbma_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire bbma_pkg::t_sts i_sts,
    output bbma_pkg::t_cmd     o_cmd
);

    bbma_pkg::t_state r_state;
    bbma_pkg::t_state n_state;
    logic             w_early;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Requests that finish without touching the map
    assign w_early = ((i_sts.op == bbma_pkg::OP_READ || i_sts.op == bbma_pkg::OP_WRITE)
                      && i_sts.idx_oor)
                   || (i_sts.op == bbma_pkg::OP_NOP)
                   || (i_sts.op == bbma_pkg::OP_ALLOC && i_sts.start_oor);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            bbma_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bbma_pkg::S_DISPATCH;
                end
            end
            bbma_pkg::S_DISPATCH: begin
                if (w_early) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = bbma_pkg::S_RESP;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = bbma_pkg::S_SCAN;
                end
            end
            bbma_pkg::S_SCAN: begin
                case (i_sts.op)
                    bbma_pkg::OP_WRITE: begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.res_ld = 1'b1;
                        n_state      = bbma_pkg::S_RESP;
                    end
                    bbma_pkg::OP_ALLOC: begin
                        if (i_sts.hit) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.res_ld = 1'b1;
                            n_state      = bbma_pkg::S_RESP;
                        end else if (i_sts.last_word) begin
                            o_cmd.res_ld = 1'b1;
                            n_state      = bbma_pkg::S_RESP;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_next = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.res_ld = 1'b1;
                        n_state      = bbma_pkg::S_RESP;
                    end
                endcase
            end
            bbma_pkg::S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = bbma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbma_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bbma_dpath.sv =====
`default_nettype none

module bbma_dpath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bbma_pkg::t_cmd                      i_cmd,
    output bbma_pkg::t_sts                           o_sts,
    input  wire logic [bbma_pkg::IN_TDATA_W-1:0]     i_req_data,
    input  wire logic [bbma_pkg::OP_W-1:0]           i_req_op,
    input  wire logic                                i_cfg_wr,
    input  wire logic [bbma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bbma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_ready,
    output logic [bbma_pkg::OUT_TDATA_W-1:0]         o_res_data,
    output logic [bbma_pkg::STATUS_W-1:0]            o_res_status
);

    localparam int IDX_W  = bbma_pkg::IDX_W;
    localparam int LIM_W  = bbma_pkg::LIM_W;
    localparam int WORD_W = bbma_pkg::WORD_W;
    localparam int BIT_W  = bbma_pkg::BIT_W;
    localparam int ADDR_W = bbma_pkg::ADDR_W;

    // Configuration
    logic [IDX_W-1:0] r_first;
    logic [LIM_W-1:0] r_count;
    logic [LIM_W-1:0] w_lim;

    // Request
    logic [bbma_pkg::OP_W-1:0] r_op;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_val;
    logic [ADDR_W-1:0]         r_addr;

    // Map storage; a row not yet written reads as all free
    logic [WORD_W-1:0]    r_mem [bbma_pkg::NUM_WORDS];
    logic [bbma_pkg::NUM_WORDS-1:0] r_row_vld;
    logic [WORD_W-1:0]    r_rdata;
    logic                 r_rd_vld;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic [WORD_W-1:0]    w_word;
    logic [WORD_W-1:0]    w_wdata;

    // Scan
    logic [ADDR_W:0]      w_addr_inc;
    logic [LIM_W-1:0]     w_next_base;
    logic [WORD_W-1:0]    w_elig;
    logic [WORD_W-1:0]    w_free;
    logic [BIT_W-1:0]     w_pos;
    logic                 w_hit;
    logic                 w_idx_oor;
    logic                 w_start_oor;

    // Result staging and output register
    logic [bbma_pkg::STATUS_W-1:0] n_res_status;
    logic [IDX_W-1:0]              n_res_blk;
    logic                          n_res_occ;
    logic [bbma_pkg::STATUS_W-1:0] r_res_status;
    logic [IDX_W-1:0]              r_res_blk;
    logic                          r_res_occ;
    logic                          r_out_vld;
    logic [bbma_pkg::STATUS_W-1:0] r_out_status;
    logic [IDX_W-1:0]              r_out_blk;
    logic                          r_out_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_count <= bbma_pkg::RST_BLOCK_COUNT;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == bbma_pkg::CFG_FIRST_DATA_BLOCK) begin
                r_first <= i_cfg_data[IDX_W-1:0];
            end else if (i_cfg_index == bbma_pkg::CFG_BLOCK_COUNT) begin
                r_count <= i_cfg_data[LIM_W-1:0];
            end
        end
    end

    assign w_lim = (r_count > LIM_W'(bbma_pkg::LIMIT_CAP)) ? LIM_W'(bbma_pkg::LIMIT_CAP)
                                                           : r_count;

    assign w_addr_inc = {1'b0, r_addr} + (ADDR_W+1)'(1);
    assign w_rd_addr  = i_cmd.rd_next ? w_addr_inc[ADDR_W-1:0] : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_op;
            r_idx <= i_req_data[IDX_W-1:0];
            r_val <= i_req_data[bbma_pkg::IN_VAL_BIT];
            if (i_req_op == bbma_pkg::OP_ALLOC) begin
                r_addr <= r_first[IDX_W-1:BIT_W];
            end else begin
                r_addr <= i_req_data[IDX_W-1:BIT_W];
            end
        end else if (i_cmd.rd_next) begin
            r_addr <= w_addr_inc[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata  <= r_mem[w_rd_addr];
            r_rd_vld <= r_row_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_row_vld[r_addr] <= 1'b1;
        end
    end

    assign w_word = r_rd_vld ? r_rdata : '0;

    // Blocks of this word that lie in [first_data_block, limit)
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_elig[b] = ((r_addr != r_first[IDX_W-1:BIT_W]) || (BIT_W'(b) >= r_first[BIT_W-1:0]))
                     && (({1'b0, r_addr} != w_lim[LIM_W-1:BIT_W])
                         || (BIT_W'(b) < w_lim[BIT_W-1:0]));
        end
    end

    assign w_free = ~w_word & w_elig;
    assign w_hit  = |w_free;

    // Lowest free block in the word
    always_comb begin
        w_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_pos = BIT_W'(b);
            end
        end
    end

    assign w_next_base = {w_addr_inc, {BIT_W{1'b0}}};
    assign w_idx_oor   = {1'b0, r_idx} >= w_lim;
    assign w_start_oor = {1'b0, r_first} >= w_lim;

    always_comb begin
        w_wdata = w_word;
        if (r_op == bbma_pkg::OP_ALLOC) begin
            w_wdata[w_pos] = 1'b1;
        end else begin
            w_wdata[r_idx[BIT_W-1:0]] = r_val;
        end
    end

    always_comb begin
        n_res_status = bbma_pkg::ST_OK;
        n_res_blk    = '0;
        n_res_occ    = 1'b0;
        case (r_op)
            bbma_pkg::OP_READ: begin
                if (w_idx_oor) begin
                    n_res_status = bbma_pkg::ST_RANGE;
                end else begin
                    n_res_occ = w_word[r_idx[BIT_W-1:0]];
                end
            end
            bbma_pkg::OP_WRITE: begin
                if (w_idx_oor) begin
                    n_res_status = bbma_pkg::ST_RANGE;
                end
            end
            bbma_pkg::OP_ALLOC: begin
                if (!w_start_oor && w_hit) begin
                    n_res_blk = {r_addr, w_pos};
                end else begin
                    n_res_status = bbma_pkg::ST_FULL;
                end
            end
            default: begin
                n_res_status = bbma_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_res_status <= n_res_status;
            r_res_blk    <= n_res_blk;
            r_res_occ    <= n_res_occ;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_blk    <= r_res_blk;
            r_out_occ    <= r_res_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.idx_oor   = w_idx_oor;
    assign o_sts.start_oor = w_start_oor;
    assign o_sts.hit       = w_hit;
    assign o_sts.last_word = w_next_base >= w_lim;
    assign o_sts.out_free  = !r_out_vld || i_res_ready;

    assign o_res_valid  = r_out_vld;
    assign o_res_status = r_out_status;
    assign o_res_data   = {(bbma_pkg::OUT_TDATA_W - IDX_W - 1)'(0), r_out_occ, r_out_blk};

endmodule

`default_nettype wire

// ===== rtl/bbma_checker.sv =====
`default_nettype none

module bbma_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [bbma_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input wire logic [bbma_pkg::OP_W-1:0]           s_axis_tuser,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [bbma_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic [bbma_pkg::STATUS_W-1:0]       m_axis_tuser,
    input wire logic                                i_cfg_valid,
    input wire logic                                o_cfg_ready,
    input wire logic [bbma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input wire logic [bbma_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != bbma_pkg::ST_RSVD)
        else $error("reserved status code");

    // failed requests carry no block and no bit
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != bbma_pkg::ST_OK |-> m_axis_tdata == '0)
        else $error("failed request with non-zero payload");

    // a read that sees a used bit returns no block
    a_occ_no_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[bbma_pkg::OUT_OCC_BIT] |->
            m_axis_tdata[bbma_pkg::IDX_W-1:0] == '0)
        else $error("occupied bit with a block number");

endmodule

bind block_bitmap_allocator_unit bbma_checker u_bbma_checker (.*);

`default_nettype wire
